// ----- design/gb3_pkg.sv -----
// Shared constants and types of the 3x3 RGB blur block.
`default_nettype none
package gb3_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int FW_W      = 11;
   localparam int FH_W      = 12;
   // The input row runs one row past the frame while the last results drain.
   localparam int ROW_W     = FH_W + 1;
   localparam int CHAN_W    = 8;
   localparam int PIX_W     = 3 * CHAN_W;
   localparam int LINE_W    = 2 * PIX_W;
   localparam int SUM_W     = CHAN_W + 4;
   localparam int CSR_W     = 12;

   localparam int OUT_DEPTH = 4;
   localparam int OPTR_W    = $clog2(OUT_DEPTH);
   localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

   localparam logic [0:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [0:0] CSR_FRAME_HEIGHT = 1'd1;

   localparam logic [0:0] OP_PIXEL = 1'd0;
   localparam logic [0:0] OP_DRAIN = 1'd1;

   typedef logic [PIX_W-1:0] pixel_type;

   typedef struct packed {
      logic              en;
      logic [COL_W-1:0]  addr;
      logic [LINE_W-1:0] data;
   } line_write_type;

   // Which taps of the window lie inside the frame, and whether a result is due.
   typedef struct packed {
      logic emit;
      logic ok_row0;
      logic ok_row2;
      logic ok_col0;
      logic ok_col2;
      logic last;
   } tap_info_type;

   typedef struct packed {
      logic      last;
      pixel_type pix;
   } result_type;

endpackage
`default_nettype wire

// ----- design/gb3_line_store.sv -----
// Line store memory holding the two previous rows, with same-entry forwarding.
`default_nettype none
module gb3_line_store (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [gb3_pkg::COL_W-1:0]   rd_addr,
   input  gb3_pkg::line_write_type     wr,
   output logic [gb3_pkg::LINE_W-1:0]  rd_data
);
   import gb3_pkg::*;

   logic [LINE_W-1:0] mem [MAX_WIDTH];
   logic [LINE_W-1:0] rd_data_ff;
   logic [LINE_W-1:0] fwd_data_ff;
   logic              fwd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // A write to the entry being read in the same cycle lands after the read,
   // so its data is carried along and replaces the stale word.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         fwd_hit_ff  <= wr.en && (wr.addr == rd_addr);
         fwd_data_ff <= wr.data;
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

endmodule
`default_nettype wire

// ----- design/gb3_out_fifo.sv -----
// Small result queue that decouples the filter pipeline from the output side.
`default_nettype none
module gb3_out_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  gb3_pkg::result_type  push_data,
   input  logic                 pop,
   output logic                 out_valid,
   output gb3_pkg::result_type  out_data
);
   import gb3_pkg::*;

   result_type        slot_ff [OUT_DEPTH];
   logic [OPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [OPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + OPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + OPTR_W'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + OCNT_W'(1);
         2'b01:   count_in = count_ff - OCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// ----- design/gaussian_blur_3x3_rgb.sv -----
// Top level of the streaming 3x3 binomial blur for RGB pixels with zero padding.
//
//   channel   direction   payload
//   req_*     in          tdata: red_in, green_in, blue_in; tuser: operation
//   rsp_*     out         tdata: red_out, green_out, blue_out; tlast: frame_end
//   csr_*     in          write enable, register index, write data
//
// One item is taken per clock while req_tready is high. A result enters the queue
// after the item that completes its window passes the line store read register and
// the window register.
// Reset clears the control state only; the line stores need no clearing pass.
// Input is held off only while the four-entry result queue is committed to
// results not yet taken.
`default_nettype none
module gaussian_blur_3x3_rgb (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [gb3_pkg::PIX_W-1:0]   req_tdata,  // red_in, green_in, blue_in
   input  logic [0:0]                  req_tuser,  // operation
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [gb3_pkg::PIX_W-1:0]   rsp_tdata,  // red_out, green_out, blue_out
   output logic                        rsp_tlast,
   input  logic                        csr_we,
   input  logic [0:0]                  csr_addr,
   input  logic [gb3_pkg::CSR_W-1:0]   csr_wdata
);
   import gb3_pkg::*;

   logic [FW_W-1:0]   fw_ff, fw_in;
   logic [FH_W-1:0]   fh_ff, fh_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  res_col_ff, res_col_in;
   logic [FH_W-1:0]   res_row_ff, res_row_in;
   logic [OCNT_W-1:0] occ_ff, occ_in;

   logic              req_fire;
   logic              drain;
   logic              act;
   logic              emit;
   logic [FW_W-1:0]   col_inc;
   logic [FW_W-1:0]   res_col_inc;
   logic [FW_W-1:0]   width_val;
   logic [FH_W-1:0]   height_val;
   tap_info_type      info;
   pixel_type         px;

   logic              s1_valid_ff;
   logic [COL_W-1:0]  s1_addr_ff;
   pixel_type         s1_px_ff;
   tap_info_type      s1_info_ff;
   logic              s2_valid_ff;
   tap_info_type      s2_info_ff;

   logic [LINE_W-1:0] line_rd;
   line_write_type    line_wr;
   pixel_type         upper_px;
   pixel_type         middle_px;
   pixel_type         win_ff [3][3];

   logic [SUM_W-1:0]  sum [3];
   logic              ok_row [3];
   logic              ok_col [3];
   result_type        res;
   result_type        out_res;
   logic              pop;

   assign req_fire = req_tvalid && req_tready;
   assign drain    = row_ff >= {1'b0, fh_ff};
   assign act      = req_fire && (drain || req_tuser == OP_PIXEL);
   assign emit     = (row_ff >= ROW_W'(2)) || (row_ff == ROW_W'(1) && col_ff != '0);
   assign px       = drain ? '0 : req_tdata;
   assign col_inc     = {1'b0, col_ff} + FW_W'(1);
   assign res_col_inc = {1'b0, res_col_ff} + FW_W'(1);

   always_comb begin
      info.emit    = emit;
      info.ok_row0 = (res_row_ff != '0);
      info.ok_row2 = (res_row_ff != fh_ff - FH_W'(1));
      info.ok_col0 = (res_col_ff != '0);
      info.ok_col2 = ({1'b0, res_col_ff} != fw_ff - FW_W'(1));
      info.last    = !info.ok_row2 && !info.ok_col2;
   end

   // Out-of-range writes are folded into the legal range.
   always_comb begin
      width_val  = csr_wdata[FW_W-1:0];
      height_val = csr_wdata[FH_W-1:0];
      if (width_val == '0) begin
         width_val = FW_W'(1);
      end else if (width_val > FW_W'(MAX_WIDTH)) begin
         width_val = FW_W'(MAX_WIDTH);
      end
      if (height_val == '0) begin
         height_val = FH_W'(1);
      end
   end

   always_comb begin
      fw_in      = fw_ff;
      fh_in      = fh_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      res_col_in = res_col_ff;
      res_row_in = res_row_ff;
      priority if (csr_we) begin
         unique case (csr_addr)
            CSR_FRAME_WIDTH:  fw_in = width_val;
            CSR_FRAME_HEIGHT: fh_in = height_val;
            default:          fw_in = fw_ff;
         endcase
         col_in     = '0;
         row_in     = '0;
         res_col_in = '0;
         res_row_in = '0;
      end else if (act) begin
         if (col_inc >= fw_ff) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
         if (emit) begin
            if (res_col_inc >= fw_ff) begin
               res_col_in = '0;
               res_row_in = res_row_ff + FH_W'(1);
            end else begin
               res_col_in = res_col_inc[COL_W-1:0];
            end
            // The final result of a frame starts the next frame.
            if (info.last) begin
               col_in     = '0;
               row_in     = '0;
               res_col_in = '0;
               res_row_in = '0;
            end
         end
      end else begin
         col_in = col_ff;
      end
   end

   // Results owed to the queue: every emitting item holds a slot from acceptance.
   always_comb begin
      occ_in = occ_ff;
      unique case ({act && emit, pop})
         2'b10:   occ_in = occ_ff + OCNT_W'(1);
         2'b01:   occ_in = occ_ff - OCNT_W'(1);
         default: occ_in = occ_ff;
      endcase
   end

   assign req_tready = (occ_ff < OCNT_W'(OUT_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff       <= FW_W'(640);
         fh_ff       <= FH_W'(480);
         col_ff      <= '0;
         row_ff      <= '0;
         res_col_ff  <= '0;
         res_row_ff  <= '0;
         occ_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         fw_ff       <= fw_in;
         fh_ff       <= fh_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         res_col_ff  <= res_col_in;
         res_row_ff  <= res_row_in;
         occ_ff      <= occ_in;
         s1_valid_ff <= act;
         s2_valid_ff <= s1_valid_ff && s1_info_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (act) begin
         s1_addr_ff <= col_ff;
         s1_px_ff   <= px;
         s1_info_ff <= info;
      end
      if (s1_valid_ff) begin
         s2_info_ff <= s1_info_ff;
      end
   end

   gb3_line_store u_line_store (
      .clock   (clock),
      .rd_en   (act),
      .rd_addr (col_ff),
      .wr      (line_wr),
      .rd_data (line_rd)
   );

   assign upper_px     = line_rd[LINE_W-1:PIX_W];
   assign middle_px    = line_rd[PIX_W-1:0];
   assign line_wr.en   = s1_valid_ff;
   assign line_wr.addr = s1_addr_ff;
   assign line_wr.data = {middle_px, s1_px_ff};

   // Rows of the window run top to bottom, columns left to right.
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= upper_px;
         win_ff[1][2] <= middle_px;
         win_ff[2][2] <= s1_px_ff;
      end
   end

   always_comb begin
      ok_row[0] = s2_info_ff.ok_row0;
      ok_row[1] = 1'b1;
      ok_row[2] = s2_info_ff.ok_row2;
      ok_col[0] = s2_info_ff.ok_col0;
      ok_col[1] = 1'b1;
      ok_col[2] = s2_info_ff.ok_col2;
   end

   // Kernel weights are 1, 2 or 4: a shift by one for each centered axis.
   always_comb begin
      logic [SUM_W-1:0] term;
      for (int k = 0; k < 3; k++) begin
         sum[k] = '0;
         for (int r = 0; r < 3; r++) begin
            for (int s = 0; s < 3; s++) begin
               term = SUM_W'(win_ff[r][s][k*CHAN_W +: CHAN_W]);
               if (r == 1) begin
                  term = term << 1;
               end
               if (s == 1) begin
                  term = term << 1;
               end
               if (ok_row[r] && ok_col[s]) begin
                  sum[k] = sum[k] + term;
               end
            end
         end
      end
   end

   always_comb begin
      res.last = s2_info_ff.last;
      for (int k = 0; k < 3; k++) begin
         res.pix[k*CHAN_W +: CHAN_W] = sum[k][SUM_W-1:4];
      end
   end

   gb3_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_data (res),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_data  (out_res)
   );

   assign pop       = rsp_tvalid && rsp_tready;
   assign rsp_tdata = out_res.pix;
   assign rsp_tlast = out_res.last;

endmodule
`default_nettype wire
